/* rtl/swiglu_activation_defines.svh */
// ---------------------------------------------------------------------------
// SwiGLU activation assertion macros
// Shared concurrent assertion forms for the activation block.
// ---------------------------------------------------------------------------
`ifndef SWIGLU_ACTIVATION_DEFINES_SVH
`define SWIGLU_ACTIVATION_DEFINES_SVH

// same-cycle implication
`define SWG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swiglu check failed");

// next-cycle implication
`define SWG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swiglu check failed");

`endif

/* rtl/swg_pkg.sv */
// ---------------------------------------------------------------------------
// SwiGLU package
// Beat types, controller/datapath links and the Q16 sigmoid table.
// ---------------------------------------------------------------------------
package swg_pkg;

   localparam int MAX_HALF_WIDTH     = 1024;
   localparam int SIGMOID_TABLE_SIZE = 256;
   localparam int ADDR_W             = $clog2(MAX_HALF_WIDTH);
   localparam int HW_W               = 11;
   localparam int SIG_W              = 17;
   localparam logic [SIG_W-1:0] ONE_Q16 = SIG_W'(65536);

   typedef struct packed {
      logic signed [15:0] element_value;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic signed [15:0] swiglu_value;
      logic               row_end;
      logic               tensor_end;
   } rsp_type;

   typedef struct packed {
      logic              gate_we;
      logic              gate_re;
      logic              load_out;
      logic [ADDR_W-1:0] addr;
      logic              row_end;
      logic              tensor_end;
   } swg_cmd_type;

   typedef struct packed {
      logic out_free;
   } swg_status_type;

   typedef logic [SIGMOID_TABLE_SIZE:0][SIG_W-1:0] sig_table_type;

   // restoring shift-and-subtract quotient, used only while building the table
   function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem    = rem - {1'b0, d};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   num;
      logic [63:0]   f;
      logic [63:0]   term;
      logic [63:0]   e;
      logic [63:0]   den;
      longint        sum;
      for (int k = 0; k <= SIGMOID_TABLE_SIZE; k++) begin
         num  = 64'(k) * 64'd8;
         f    = (num % 64'(SIGMOID_TABLE_SIZE)) << 32;
         f    = f / 64'(SIGMOID_TABLE_SIZE);
         sum  = longint'(64'd1 << 32);
         term = 64'd1 << 32;
         for (int i = 1; i <= 24; i++) begin
            term = div_u64((term * f) >> 32, 64'(i));
            if ((i & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         e = 64'(sum);
         for (int j = 0; j < (k * 8) / SIGMOID_TABLE_SIZE; j++) begin
            e = (e * 64'd1580030169 + (64'd1 << 31)) >> 32;
         end
         den    = (64'd1 << 32) + e;
         tbl[k] = SIG_W'(div_u64((64'd1 << 48) + (den >> 1), den));
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

/* rtl/swg_ctrl.sv */
// ---------------------------------------------------------------------------
// SwiGLU controller
// Tracks the row position, steers gate beats into the buffer and sequences one y beat through the datapath.
// ---------------------------------------------------------------------------
module swg_ctrl import swg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             last_element,
   input  logic             csr_we,
   input  logic [HW_W-1:0]  csr_wdata,
   input  swg_status_type   status,
   output swg_cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_INTERP = 6'b000100,
      ST_MUL1   = 6'b001000,
      ST_MUL2   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [HW_W-1:0]   hw_ff, hw_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              second_ff, second_in;
   logic [HW_W-1:0]   d_eff;
   logic [ADDR_W-1:0] pos_cur;
   logic [HW_W-1:0]   pos_inc;
   logic              accept;
   logic              wrap;

   always_comb begin
      if (hw_ff == '0) begin
         d_eff = HW_W'(1);
      end else if (hw_ff > HW_W'(MAX_HALF_WIDTH)) begin
         d_eff = HW_W'(MAX_HALF_WIDTH);
      end else begin
         d_eff = hw_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign pos_cur   = ({1'b0, pos_ff} >= d_eff) ? '0 : pos_ff;
   assign pos_inc   = {1'b0, pos_cur} + HW_W'(1);
   assign wrap      = (pos_inc >= d_eff);

   always_comb begin
      state_in  = state_ff;
      hw_in     = hw_ff;
      pos_in    = pos_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.addr  = pos_cur;
      cmd.row_end    = wrap || last_element;
      cmd.tensor_end = last_element;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               hw_in     = csr_wdata;
               pos_in    = '0;
               second_in = 1'b0;
            end else if (accept) begin
               pos_in = pos_inc[ADDR_W-1:0];
               if (!second_ff) begin
                  cmd.gate_we = 1'b1;
                  if (wrap) begin
                     pos_in    = '0;
                     second_in = 1'b1;
                  end
               end else begin
                  cmd.gate_re = 1'b1;
                  state_in    = ST_LOOKUP;
                  if (wrap) begin
                     pos_in    = '0;
                     second_in = 1'b0;
                  end
               end
               if (last_element) begin
                  pos_in    = '0;
                  second_in = 1'b0;
               end
            end
         end
         ST_LOOKUP: state_in = ST_INTERP;
         ST_INTERP: state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         hw_ff     <= HW_W'(1);
         pos_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hw_ff     <= hw_in;
         pos_ff    <= pos_in;
         second_ff <= second_in;
      end
   end

endmodule

/* rtl/swg_datapath.sv */
// ---------------------------------------------------------------------------
// SwiGLU datapath
// Gate row buffer, sigmoid interpolation, products, rounding, output beat.
// ---------------------------------------------------------------------------
module swg_datapath import swg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  swg_cmd_type    cmd,
   output swg_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   logic signed [15:0] gate_mem [MAX_HALF_WIDTH];

   logic signed [15:0] gate_ff;
   logic signed [15:0] y_ff;
   logic               rend_ff;
   logic               tend_ff;
   logic [SIG_W-1:0]   base_ff, base_in;
   logic [SIG_W-1:0]   diff_ff, diff_in;
   logic [2:0]         ra_ff, ra_in;
   logic               sat_ff, sat_in;
   logic               neg_ff, neg_in;
   logic [SIG_W-1:0]   s_ff, s_in;
   logic signed [33:0] xs_ff, xs_in;
   logic signed [49:0] prod_ff, prod_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [16:0]        mag;
   logic [7:0]         idx;
   logic [SIG_W+2:0]   frac;
   logic [SIG_W:0]     interp;
   logic [SIG_W-1:0]   s_pos;
   logic signed [50:0] rounded;
   logic signed [26:0] q;

   always_ff @(posedge clock) begin
      if (cmd.gate_we) begin
         gate_mem[cmd.addr] <= req_data.element_value;
      end
      if (cmd.gate_re) begin
         gate_ff <= gate_mem[cmd.addr];
         y_ff    <= req_data.element_value;
         rend_ff <= cmd.row_end;
         tend_ff <= cmd.tensor_end;
      end
   end

   always_comb begin
      neg_in  = gate_ff[15];
      mag     = neg_in ? 17'(-{gate_ff[15], gate_ff}) : 17'({1'b0, gate_ff});
      sat_in  = (mag >= 17'd2048);
      idx     = mag[10:3];
      ra_in   = mag[2:0];
      base_in = SIG_TABLE[idx];
      diff_in = SIG_TABLE[9'(idx) + 9'd1] - SIG_TABLE[idx];
   end

   always_comb begin
      frac   = (SIG_W+3)'(diff_ff * ra_ff) + (SIG_W+3)'(4);
      interp = (SIG_W+1)'(base_ff) + (SIG_W+1)'(frac >> 3);
      if (sat_ff || interp > (SIG_W+1)'(ONE_Q16)) begin
         s_pos = ONE_Q16;
      end else begin
         s_pos = interp[SIG_W-1:0];
      end
      s_in = neg_ff ? ONE_Q16 - s_pos : s_pos;
   end

   assign xs_in   = gate_ff * $signed({1'b0, s_ff});
   assign prod_in = xs_ff * y_ff;

   always_comb begin
      rounded = 51'(prod_ff) + 51'sd8388608;
      q       = 27'(rounded >>> 24);
      rsp_in.row_end    = rend_ff;
      rsp_in.tensor_end = tend_ff;
      if (q > 27'sd32767) begin
         rsp_in.swiglu_value = 16'sh7FFF;
      end else if (q < -27'sd32768) begin
         rsp_in.swiglu_value = 16'sh8000;
      end else begin
         rsp_in.swiglu_value = q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      diff_ff <= diff_in;
      ra_ff   <= ra_in;
      sat_ff  <= sat_in;
      neg_ff  <= neg_in;
      s_ff    <= s_in;
      xs_ff   <= xs_in;
      prod_ff <= prod_in;
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

/* rtl/swiglu_activation.sv */
// ---------------------------------------------------------------------------
// SwiGLU activation top level
// Gate half of each row is buffered; each y beat yields x*sigmoid(x)*y.
// ---------------------------------------------------------------------------
// Gate beats: one per cycle, no result.
// Y beats: each passes the gate read, lookup, interpolation and two multiplier
// stages, and no new beat is taken until its result is registered.
// A held result beat stalls the next y beat only when its own result is ready.
// Synchronous active-high reset: idle, half width 1, row position zero.
// Gate buffer contents are not cleared by reset.
`include "swiglu_activation_defines.svh"

module swiglu_activation import swg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   input  logic            csr_we,
   input  logic [HW_W-1:0] csr_wdata
);

   swg_cmd_type    cmd;
   swg_status_type status;

   swg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .last_element (req_data.last_element),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .status       (status),
      .cmd          (cmd)
   );

   swg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `SWG_ASSERT_NOW(a_tend_has_rend, clock, reset, rsp_valid && rsp_data.tensor_end, rsp_data.row_end)
   `SWG_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
   `SWG_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_out, rsp_valid)

endmodule
